@@ sv/chained_hash_table_top_macros.svh @@
// assertion macros shared by the checker
`ifndef CHAINED_HASH_TABLE_TOP_MACROS_SVH
`define CHAINED_HASH_TABLE_TOP_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define CHT_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed");
// next-cycle implication checked on every rising clock edge outside reset
`define CHT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed");
`endif

@@ sv/cht_pkg.sv @@
// ----------------------------------------------------------------------------
// cht_pkg
// operation and status codes of the chained hash table
// ----------------------------------------------------------------------------
package cht_pkg;
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_SEARCH = 2'd1,
    OP_DELETE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
endpackage

@@ sv/cht_ram.sv @@
// ----------------------------------------------------------------------------
// cht_ram
// single port write, single port read ram with registered read data
// ----------------------------------------------------------------------------
module cht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ sv/chained_hash_table_top.sv @@
// Chained hash table over a fixed node pool, one item in flight at a time.
// Clear goes straight to the result; insert scans the pool for the first free node
// (the scan tests one occupancy bit a cycle) and reports full when none is free.
// Search and delete read and compare one chain node per step, plus an unlink step
// when a delete frees a node behind the head; next input once the result is taken.
// Reset (synchronous, rst high) empties all buckets and the pool; node memories keep data.
module chained_hash_table_top
  import cht_pkg::*;
#(
  parameter int NUM_BUCKETS = 16,
  parameter int POOL_NODES  = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         operation,
  input  logic signed [31:0] entry_key,
  input  logic signed [31:0] entry_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic signed [31:0] found_key
);
  localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int NW = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
  localparam int LW = $clog2(POOL_NODES + 1);
  localparam int SW = $clog2(POOL_NODES + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_RD, S_CHK, S_UNLINK, S_OUT
  } state_t;

  state_t           state;
  op_t              op;
  logic [31:0]      key;
  logic [31:0]      val;
  logic [BW-1:0]    bkt;
  logic [LW-1:0]    link;
  logic [LW-1:0]    prev;
  logic [SW-1:0]    steps;
  logic [NW-1:0]    scan;

  // bucket heads (node index plus one, zero when empty) and occupancy bits are flip-flops
  logic [LW-1:0]          heads [NUM_BUCKETS];
  logic [POOL_NODES-1:0]  in_use;

  // node memory write and read ports
  logic             n_we;
  logic [NW-1:0]    n_waddr;
  logic [NW-1:0]    n_raddr;
  logic [31:0]      k_wdata, v_wdata, k_rdata, v_rdata;
  logic [LW-1:0]    l_wdata, l_rdata;
  logic             l_we;
  logic [NW-1:0]    l_waddr;

  cht_ram #(.WIDTH(32), .DEPTH(POOL_NODES)) u_keys (
    .clk(clk), .we(n_we), .waddr(n_waddr), .wdata(k_wdata),
    .raddr(n_raddr), .rdata(k_rdata));
  cht_ram #(.WIDTH(32), .DEPTH(POOL_NODES)) u_vals (
    .clk(clk), .we(n_we), .waddr(n_waddr), .wdata(v_wdata),
    .raddr(n_raddr), .rdata(v_rdata));
  cht_ram #(.WIDTH(LW), .DEPTH(POOL_NODES)) u_links (
    .clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
    .raddr(n_raddr), .rdata(l_rdata));

  // bucket of the incoming value
  logic [31:0] mag;
  assign mag = entry_value[31] ? (~entry_value + 32'd1) : entry_value;
  logic [BW-1:0] in_bkt;
  assign in_bkt = BW'(mag % 32'(NUM_BUCKETS));

  assign in_ready = (state == S_IDLE) && !out_valid;
  assign n_raddr  = NW'(link - LW'(1));

  // node memory writes
  always_comb begin
    n_we    = (state == S_SCAN) && !in_use[scan];
    n_waddr = scan;
    k_wdata = key;
    v_wdata = val;
    l_we    = n_we || (state == S_UNLINK);
    l_waddr = n_we ? scan : NW'(prev - LW'(1));
    l_wdata = n_we ? heads[bkt] : l_rdata;
  end

  // control sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      in_use    <= '0;
      for (int i = 0; i < NUM_BUCKETS; i++) heads[i] <= '0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            op        <= op_t'(operation);
            key       <= entry_key;
            val       <= entry_value;
            bkt       <= in_bkt;
            link      <= heads[in_bkt];
            prev      <= '0;
            steps     <= '0;
            scan      <= '0;
            found_key <= '0;
            case (op_t'(operation))
              OP_INSERT: state <= S_SCAN;
              OP_CLEAR: begin
                in_use <= '0;
                for (int i = 0; i < NUM_BUCKETS; i++) heads[i] <= '0;
                status <= ST_OK;
                state  <= S_OUT;
              end
              default: begin
                status <= ST_NOT_FOUND;
                state  <= S_RD;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (!in_use[scan]) begin
            in_use[scan] <= 1'b1;
            heads[bkt]   <= LW'(scan) + LW'(1);
            status       <= ST_OK;
            state        <= S_OUT;
          end else if (scan == NW'(POOL_NODES - 1)) begin
            status <= ST_FULL;
            state  <= S_OUT;
          end else begin
            scan <= scan + NW'(1);
          end
        end
        S_RD: begin
          if (link == '0 || steps == SW'(POOL_NODES)) state <= S_OUT;
          else state <= S_CHK;
        end
        S_CHK: begin
          if (v_rdata == val) begin
            status <= ST_OK;
            if (op == OP_SEARCH) begin
              found_key <= k_rdata;
              state     <= S_OUT;
            end else begin
              in_use[n_raddr] <= 1'b0;
              if (prev == '0) begin
                heads[bkt] <= l_rdata;
                state      <= S_OUT;
              end else begin
                state <= S_UNLINK;
              end
            end
          end else begin
            prev  <= link;
            link  <= l_rdata;
            steps <= steps + SW'(1);
            state <= S_RD;
          end
        end
        S_UNLINK: state <= S_OUT;
        S_OUT: begin
          out_valid <= 1'b1;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

@@ sv/cht_checker.sv @@
// ----------------------------------------------------------------------------
// cht_checker
// port level checks of the chained hash table, bound to the top level
// ----------------------------------------------------------------------------
`include "chained_hash_table_top_macros.svh"
module cht_checker
  import cht_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  operation,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  status,
  input logic [31:0] found_key
);
  // no new transfer while a result waits
  `CHT_ASSERT_IMPL(a_no_accept_busy, clk, rst, out_valid, !in_ready)
  // result waits until taken
  `CHT_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)
  // waiting input keeps its operation
  `CHT_ASSERT_NEXT(a_in_hold, clk, rst, in_valid && !in_ready, in_valid && $stable(operation))
  // only a found status carries a key
  `CHT_ASSERT_IMPL(a_key_zero, clk, rst, out_valid && status != ST_OK, found_key == '0)
  // status code range
  `CHT_ASSERT_IMPL(a_status_range, clk, rst, out_valid,
    status == ST_OK || status == ST_NOT_FOUND || status == ST_FULL)
endmodule

bind chained_hash_table_top cht_checker u_cht_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .operation(operation), .out_valid(out_valid), .out_ready(out_ready),
  .status(status), .found_key(found_key));

@@ sim/chained_hash_table_top_test.sv @@
// ----------------------------------------------------------------------------
// chained_hash_table_top_test
// Drives inserts, searches, deletes and clears into the chained hash table
// and compares every status and found key against an in-bench table copy.
// ----------------------------------------------------------------------------
module chained_hash_table_top_test;
  import cht_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NB = 16;
  localparam int NP = 64;

  typedef struct {
    logic [1:0]  status;
    logic [31:0] found_key;
  } answer_t;

  int unsigned errors = 0;

  // mismatch report
  task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
    $display("mismatch %s: got %0h expected %0h", what, got, exp);
    errors++;
  endtask

  // table copy and queue of pending answers
  class table_scoreboard;
    int unsigned heads[NB];
    logic [31:0] keys[NP];
    logic [31:0] vals[NP];
    int unsigned links[NP];
    bit          used[NP];
    answer_t     pending[$];

    function void wipe();
      for (int i = 0; i < NB; i++) heads[i] = 0;
      for (int i = 0; i < NP; i++) begin
        used[i] = 0;
        links[i] = 0;
      end
    endfunction

    function int unsigned bucket_of(logic [31:0] v);
      logic [31:0] mag;
      mag = v[31] ? (~v + 32'd1) : v;
      return mag % NB;
    endfunction

    function int unsigned occupancy();
      int unsigned n;
      n = 0;
      for (int i = 0; i < NP; i++) n += used[i];
      return n;
    endfunction

    // note an accepted input transfer
    function void note_input(logic [1:0] op, logic [31:0] key, logic [31:0] val);
      answer_t a;
      int unsigned b, link, prev, steps, slot, n;
      b = bucket_of(val);
      a.status = ST_OK;
      a.found_key = 0;
      case (op)
        OP_INSERT: begin
          slot = NP;
          for (int i = 0; i < NP; i++)
            if (!used[i] && slot == NP) slot = i;
          if (slot == NP) a.status = ST_FULL;
          else begin
            used[slot] = 1;
            keys[slot] = key;
            vals[slot] = val;
            links[slot] = heads[b];
            heads[b] = slot + 1;
          end
        end
        OP_SEARCH, OP_DELETE: begin
          a.status = ST_NOT_FOUND;
          link = heads[b];
          prev = 0;
          steps = 0;
          while (link != 0 && steps < NP) begin
            n = link - 1;
            if (vals[n] == val) begin
              a.status = ST_OK;
              if (op == OP_SEARCH) a.found_key = keys[n];
              else begin
                if (prev == 0) heads[b] = links[n];
                else links[prev - 1] = links[n];
                used[n] = 0;
              end
              break;
            end
            prev = link;
            link = links[n];
            steps++;
          end
        end
        default: wipe();
      endcase
      pending.push_back(a);
    endfunction

    // check an accepted result transfer
    task check_result(logic [1:0] st, logic [31:0] fk);
      answer_t a;
      if (pending.size() == 0) begin
        report("unexpected result", st, 0);
        return;
      end
      a = pending.pop_front();
      if (st !== a.status) report("status", st, a.status);
      if (fk !== a.found_key) report("found_key", fk, a.found_key);
    endtask
  endclass

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  logic [1:0] operation = OP_INSERT;
  logic signed [31:0] entry_key = 0;
  logic signed [31:0] entry_value = 0;
  logic out_valid;
  logic out_ready = 0;
  logic [1:0] status;
  logic signed [31:0] found_key;

  int unsigned send_idle = 0;
  int unsigned recv_stall = 0;
  table_scoreboard sb = new();

  chained_hash_table_top dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .operation(operation), .entry_key(entry_key), .entry_value(entry_value),
    .out_valid(out_valid), .out_ready(out_ready), .status(status),
    .found_key(found_key)
  );

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  // result side: random stall and checking
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) sb.check_result(status, found_key);
      out_ready <= ($urandom_range(99) >= recv_stall);
    end
  end

  // one input transfer with random lead-in idling; valid drops only when idling
  task automatic send(input logic [1:0] op, input logic [31:0] key, input logic [31:0] val);
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    in_valid <= 1;
    operation <= op;
    entry_key <= key;
    entry_value <= val;
    do @(posedge clk); while (!in_ready);
    sb.note_input(op, key, val);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  // values from a small pool so chains collide and searches hit
  function automatic logic [31:0] pick_value();
    case ($urandom_range(9))
      0: return $urandom();
      1: return 32'h8000_0000;
      2: return 32'h7fff_ffff;
      default: return $urandom_range(40) * (($urandom_range(1) == 1) ? 1 : -1) * 16
                      + $urandom_range(3);
    endcase
  endfunction

  task automatic random_phase(input int n, input int idle, input int stall);
    logic [1:0] op;
    int unsigned r;
    send_idle = idle;
    recv_stall = stall;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 45 && sb.occupancy() < NP) op = OP_INSERT;
      else if (r < 45) op = $urandom_range(1) ? OP_INSERT : OP_DELETE;
      else if (r < 70) op = OP_SEARCH;
      else if (r < 98) op = OP_DELETE;
      else op = OP_CLEAR;
      send(op, $urandom(), pick_value());
    end
  endtask

  initial begin
    sb.wipe();
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: extremes, empty table, duplicates, full pool, clear
    send(OP_SEARCH, 0, 5);
    send(OP_DELETE, 0, 5);
    send(OP_INSERT, 32'h8000_0000, 32'h8000_0000);
    send(OP_INSERT, 32'h7fff_ffff, 32'h7fff_ffff);
    send(OP_INSERT, 32'hffff_ffff, 32'h8000_0001);
    send(OP_INSERT, 1, 16);
    send(OP_INSERT, 2, 16);
    send(OP_INSERT, 3, -16);
    send(OP_SEARCH, 0, 16);
    send(OP_DELETE, 0, 16);
    send(OP_SEARCH, 0, 16);
    send(OP_SEARCH, 0, 32'h8000_0000);
    send(OP_SEARCH, 0, 32'h7fff_ffff);
    send(OP_SEARCH, 0, 32'h8000_0001);
    send(OP_SEARCH, 0, 32);
    send(OP_CLEAR, 0, 0);
    send(OP_SEARCH, 0, 16);
    for (int i = 0; i < NP + 2; i++) send(OP_INSERT, i, i * 16);
    send(OP_DELETE, 0, 0);
    send(OP_SEARCH, 0, 48);
    send(OP_CLEAR, 0, 0);
    // random phases
    random_phase(300, 0, 0);
    drain();
    random_phase(250, 86, 0);
    random_phase(250, 0, 86);
    drain();
    random_phase(250, 38, 38);
    recv_stall = 0;
    drain();
    repeat (200) @(posedge clk);
    if (errors == 0 && sb.pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end
endmodule

@@ sim.f @@
+incdir+sv
sv/cht_pkg.sv
sv/cht_ram.sv
sv/chained_hash_table_top.sv
sv/cht_checker.sv
sim/chained_hash_table_top_test.sv
